// ===== hdl/old_pkg.sv =====
// Package: shared types and constants for the optical level deframer.
`timescale 1ns / 1ps
`default_nettype none

package old_pkg;

   localparam int FRAME_BITS   = 32;
   localparam int COUNT_W      = $clog2(FRAME_BITS + 1);
   localparam int POS_W        = $clog2(FRAME_BITS);
   localparam int LEVEL_W      = 10;
   localparam int CSR_ADDR_W   = 3;
   localparam int REQ_DATA_W   = 16;
   localparam int RSP_DATA_W   = 40;
   localparam int RSP_USER_W   = 3;

   typedef logic [LEVEL_W-1:0] level_type;
   typedef logic [COUNT_W-1:0] count_type;

   typedef enum logic [1:0] {
      SYM_ZERO    = 2'd0,
      SYM_ONE     = 2'd1,
      SYM_MARK    = 2'd2,
      SYM_UNKNOWN = 2'd3
   } symbol_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_BLACK_MAX  = 3'd0,
      CSR_WHITE_MIN  = 3'd1,
      CSR_WHITE_MAX  = 3'd2,
      CSR_MARKER_MIN = 3'd3,
      CSR_MARKER_MAX = 3'd4
   } csr_addr_type;

   localparam level_type BLACK_MAX_RST  = 10'd15;
   localparam level_type WHITE_MIN_RST  = 10'd50;
   localparam level_type WHITE_MAX_RST  = 10'd120;
   localparam level_type MARKER_MIN_RST = 10'd20;
   localparam level_type MARKER_MAX_RST = 10'd43;

   localparam count_type FRAME_FULL = count_type'(FRAME_BITS);

endpackage

`default_nettype wire

// ===== hdl/optical_level_deframer.sv =====
// Top level: brightness sample classifier and date/time frame collector.
//
// Usage: one 10-bit brightness sample enters per req_ transaction and gives
// exactly one rsp_ transaction: its symbol class (zero, one, marker, unknown)
// in rsp_tuser, and when the marker closed a frame, frame_done (in rsp_tuser) plus the
// hour/minute/day/month/year fields and the bit count in rsp_tdata (all
// zero otherwise). A marker outside a frame opens one; zero/one symbols
// inside a frame are stored first-received-MSB, up to 32 bits.
// Pipeline: the sample is registered in the input register, then classified
// and the frame state updated into the result register, which drives the
// rsp_ outputs.
// Throughput: one sample per cycle while rsp_tready stays high; the compare
// set and one store update sit between the two registers.
// Stall: with rsp_tready low the result holds; req_tready falls as soon as
// the input register holds a sample that cannot move on (in the same cycle
// when both registers are full); nothing is lost or repeated.
// Reset: synchronous, clears both valid flags, the frame state and restores
// the threshold registers to their defaults. Thresholds are to be written
// through csr_ only while the block is idle (up to the user; not enforced).
`timescale 1ns / 1ps
`default_nettype none

module optical_level_deframer (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [old_pkg::REQ_DATA_W-1:0]    req_tdata,   // [9:0] brightness
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [old_pkg::RSP_DATA_W-1:0]         rsp_tdata,   // hour, minute, day,
                                                               // month, year,
                                                               // bits_received
   output logic [old_pkg::RSP_USER_W-1:0]         rsp_tuser,   // symbol, frame_done
   input  wire logic                              csr_we,
   input  wire logic [old_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  wire logic [old_pkg::LEVEL_W-1:0]       csr_wdata
);
   import old_pkg::*;

   level_type black_max_ff, white_min_ff, white_max_ff, marker_min_ff, marker_max_ff;

   logic                  in_valid_ff;
   level_type             in_level_ff;
   logic                  out_valid_ff;
   symbol_type            out_symbol_ff;
   logic                  out_done_ff;
   logic [FRAME_BITS-1:0] out_bits_ff;
   count_type             out_count_ff;

   logic                  in_frame_ff, in_frame_in;
   logic [FRAME_BITS-1:0] frame_bits_ff, frame_bits_in;
   count_type             bit_count_ff, bit_count_in;

   symbol_type            symbol;
   logic                  advance;
   logic                  closing;
   logic                  in_black, in_white, in_marker;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   // threshold registers
   always_ff @(posedge clock) begin
      if (reset) begin
         black_max_ff  <= BLACK_MAX_RST;
         white_min_ff  <= WHITE_MIN_RST;
         white_max_ff  <= WHITE_MAX_RST;
         marker_min_ff <= MARKER_MIN_RST;
         marker_max_ff <= MARKER_MAX_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_BLACK_MAX:  black_max_ff  <= csr_wdata;
            CSR_WHITE_MIN:  white_min_ff  <= csr_wdata;
            CSR_WHITE_MAX:  white_max_ff  <= csr_wdata;
            CSR_MARKER_MIN: marker_min_ff <= csr_wdata;
            CSR_MARKER_MAX: marker_max_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_level_ff <= req_tdata[LEVEL_W-1:0];
      end
   end

   // classification, first match wins
   always_comb begin
      in_black  = in_level_ff <= black_max_ff;
      in_white  = (in_level_ff >= white_min_ff) && (in_level_ff <= white_max_ff);
      in_marker = (in_level_ff >= marker_min_ff) && (in_level_ff <= marker_max_ff);
      if (in_black) begin
         symbol = SYM_ZERO;
      end else if (in_white) begin
         symbol = SYM_ONE;
      end else if (in_marker) begin
         symbol = SYM_MARK;
      end else begin
         symbol = SYM_UNKNOWN;
      end
   end

   assign closing = (symbol == SYM_MARK) && in_frame_ff;

   // frame state update
   always_comb begin
      in_frame_in   = in_frame_ff;
      frame_bits_in = frame_bits_ff;
      bit_count_in  = bit_count_ff;
      if (symbol == SYM_MARK) begin
         in_frame_in = !in_frame_ff;
         if (!in_frame_ff) begin
            frame_bits_in = '0;
            bit_count_in  = '0;
         end
      end else if (symbol != SYM_UNKNOWN && in_frame_ff && bit_count_ff < FRAME_FULL) begin
         // first bit lands in the top position
         if (symbol == SYM_ONE) begin
            frame_bits_in[~bit_count_ff[POS_W-1:0]] = 1'b1;
         end
         bit_count_in = bit_count_ff + count_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff   <= 1'b0;
         frame_bits_ff <= '0;
         bit_count_ff  <= '0;
      end else if (advance) begin
         in_frame_ff   <= in_frame_in;
         frame_bits_ff <= frame_bits_in;
         bit_count_ff  <= bit_count_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_symbol_ff <= symbol;
         out_done_ff   <= closing;
         out_bits_ff   <= closing ? frame_bits_ff : '0;
         out_count_ff  <= closing ? bit_count_ff : '0;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = {out_done_ff, out_symbol_ff};
   assign rsp_tdata  = {2'b00,
                        out_count_ff,
                        out_bits_ff[11:0],
                        out_bits_ff[15:12],
                        out_bits_ff[20:16],
                        out_bits_ff[26:21],
                        out_bits_ff[31:27]};

`ifndef NO_ASSERTIONS
   a_done_is_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && out_done_ff |-> out_symbol_ff == SYM_MARK)
      else $error("frame_done on a non-marker symbol");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      bit_count_ff <= FRAME_FULL)
      else $error("bit count beyond frame size");

   a_quiet_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !out_done_ff |-> out_bits_ff == '0 && out_count_ff == '0)
      else $error("frame fields set without frame_done");

   a_close_leaves_frame: assert property (@(posedge clock) disable iff (reset)
      advance && closing |=> !in_frame_ff)
      else $error("frame still open after close");
`endif

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Testbench for optical_level_deframer: brightness classes and frame fields checked per sample.
`timescale 1ns / 1ps

module testbench;
   import old_pkg::*;

   localparam int IDLE_LIMIT = 2000;

   // one expected rsp_ transaction, unpacked
   typedef struct packed {
      symbol_type  symbol;
      logic        frame_done;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [4:0]  day;
      logic [3:0]  month;
      logic [11:0] year;
      logic [5:0]  bits_received;
   } deframe_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;    // [9:0] brightness
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;         // hour, minute, day, month, year, bits_received
   logic [RSP_USER_W-1:0] rsp_tuser;         // symbol, frame_done
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [LEVEL_W-1:0]    csr_wdata = '0;

   // predictor copy of thresholds and frame state
   level_type             zero_ceiling = BLACK_MAX_RST;
   level_type             one_floor    = WHITE_MIN_RST;
   level_type             one_ceiling  = WHITE_MAX_RST;
   level_type             mark_floor   = MARKER_MIN_RST;
   level_type             mark_ceiling = MARKER_MAX_RST;
   logic                  frame_open   = 1'b0;
   logic [FRAME_BITS-1:0] frame_word   = '0;
   count_type             frame_count  = '0;

   deframe_result_type    pending_results[$];
   int                    mismatches   = 0;
   int                    samples_sent = 0;
   int                    stall_left   = 0;
   int                    idle_cycles  = 0;
   bit                    bursty       = 1'b1;

   optical_level_deframer i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // mostly short gaps, a few long ones
   function automatic int idle_len();
      int r;
      if (!bursty) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(5, 40);
   endfunction

   function automatic symbol_type classify_level(level_type b);
      if (b <= zero_ceiling) return SYM_ZERO;
      if (b >= one_floor && b <= one_ceiling) return SYM_ONE;
      if (b >= mark_floor && b <= mark_ceiling) return SYM_MARK;
      return SYM_UNKNOWN;
   endfunction

   // brightness of the wanted class, range ends included; falls back to any value
   function automatic level_type pick_level(symbol_type want);
      level_type lo, hi, v;
      int tries;
      case (want)
         SYM_ZERO: begin
            lo = '0;
            hi = zero_ceiling;
         end
         SYM_ONE: begin
            lo = one_floor;
            hi = one_ceiling;
         end
         SYM_MARK: begin
            lo = mark_floor;
            hi = mark_ceiling;
         end
         default: begin
            lo = '0;
            hi = '1;
         end
      endcase
      v = '0;
      for (tries = 0; tries < 200; tries++) begin
         if (lo <= hi && tries < 100) begin
            case ($urandom_range(0, 7))
               0:       v = lo;
               1:       v = hi;
               default: v = level_type'($urandom_range(lo, hi));
            endcase
         end else begin
            v = level_type'($urandom_range(0, 1023));
         end
         if (classify_level(v) == want) return v;
      end
      return v;
   endfunction

   function automatic void predict_sample(level_type b);
      deframe_result_type r;
      r = '0;
      r.symbol = classify_level(b);
      if (r.symbol == SYM_MARK) begin
         if (!frame_open) begin
            frame_open  = 1'b1;
            frame_word  = '0;
            frame_count = '0;
         end else begin
            frame_open      = 1'b0;
            r.frame_done    = 1'b1;
            r.hour          = frame_word[31:27];
            r.minute        = frame_word[26:21];
            r.day           = frame_word[20:16];
            r.month         = frame_word[15:12];
            r.year          = frame_word[11:0];
            r.bits_received = frame_count;
         end
      end else if (r.symbol != SYM_UNKNOWN && frame_open && frame_count < FRAME_FULL) begin
         // first bit lands in the top position
         if (r.symbol == SYM_ONE) frame_word[FRAME_BITS-1-frame_count] = 1'b1;
         frame_count++;
      end
      pending_results.push_back(r);
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("ERROR at %0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      mismatches++;
   endtask

   task automatic check_field(string what, longint got, longint want);
      if (got != want) report_mismatch(what, got, want);
   endtask

   // leaves req_tvalid high at the accepting edge so back-to-back samples need no extra step
   task automatic send_sample(level_type b);
      int gap;
      gap = idle_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_W-LEVEL_W){1'b0}}, b};
      @(negedge clock);
      while (!req_tready) @(negedge clock);
      @(posedge clock);
      predict_sample(b);
      samples_sent++;
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_level(csr_addr_type idx, level_type val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      case (idx)
         CSR_BLACK_MAX:  zero_ceiling = val;
         CSR_WHITE_MIN:  one_floor    = val;
         CSR_WHITE_MAX:  one_ceiling  = val;
         CSR_MARKER_MIN: mark_floor   = val;
         CSR_MARKER_MAX: mark_ceiling = val;
         default: ;
      endcase
   endtask

   task automatic set_levels(level_type bmax, level_type wmin, level_type wmax,
                             level_type mmin, level_type mmax);
      wait_idle();
      write_level(CSR_BLACK_MAX, bmax);
      write_level(CSR_WHITE_MIN, wmin);
      write_level(CSR_WHITE_MAX, wmax);
      write_level(CSR_MARKER_MIN, mmin);
      write_level(CSR_MARKER_MAX, mmax);
   endtask

   // range edges at reset thresholds, bits outside a frame, an empty frame
   task automatic test_level_bounds();
      send_sample('0);
      send_sample(BLACK_MAX_RST);
      send_sample('1);
      send_sample(level_type'(BLACK_MAX_RST + 1));
      send_sample(level_type'(MARKER_MIN_RST - 1));
      send_sample(level_type'(MARKER_MAX_RST + 1));
      send_sample(level_type'(WHITE_MIN_RST - 1));
      send_sample(WHITE_MIN_RST);
      send_sample(WHITE_MAX_RST);
      send_sample(level_type'(WHITE_MAX_RST + 1));
      send_sample(MARKER_MIN_RST);
      send_sample(MARKER_MAX_RST);
   endtask

   // three bits with an unknown sample inside; unreceived positions must read zero
   task automatic test_short_frame();
      send_sample(level_type'(30));
      send_sample(WHITE_MAX_RST);
      send_sample('1);
      send_sample('0);
      send_sample(WHITE_MIN_RST);
      send_sample(MARKER_MAX_RST);
   endtask

   // mostly frames with random content and length (short, full or overlong), some left open, some noise bursts
   task automatic test_random_traffic(int count);
      int target, len, k;
      target = samples_sent + count;
      while (samples_sent < target) begin
         bursty = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 99) < 80) begin
            send_sample(pick_level(SYM_MARK));
            case ($urandom_range(0, 9))
               0, 1:    len = FRAME_BITS;
               2:       len = $urandom_range(FRAME_BITS + 1, FRAME_BITS + 8);
               default: len = $urandom_range(0, FRAME_BITS - 1);
            endcase
            for (k = 0; k < len; k++) begin
               if ($urandom_range(0, 19) == 0) send_sample(pick_level(SYM_UNKNOWN));
               send_sample(pick_level($urandom_range(0, 1) ? SYM_ONE : SYM_ZERO));
            end
            if ($urandom_range(0, 9) != 0) send_sample(pick_level(SYM_MARK));
         end else begin
            repeat ($urandom_range(1, 6)) send_sample(level_type'($urandom_range(0, 1023)));
         end
      end
   endtask

   task automatic test_disjoint_levels();
      set_levels(level_type'(100), level_type'(300), level_type'(600),
                 level_type'(700), level_type'(1023));
      test_random_traffic(250);
   endtask

   // black beats white, white beats marker where they overlap
   task automatic test_overlapping_levels();
      set_levels(level_type'(200), level_type'(100), level_type'(500),
                 level_type'(400), level_type'(800));
      test_random_traffic(250);
   endtask

   // inverted white range matches nothing; only level 0 is black
   task automatic test_empty_ranges();
      set_levels(level_type'(0), level_type'(900), level_type'(100),
                 level_type'(1), level_type'(1023));
      test_random_traffic(150);
   endtask

   task automatic test_all_black();
      set_levels(level_type'(1023), level_type'(0), level_type'(1023),
                 level_type'(0), level_type'(1023));
      test_random_traffic(50);
   endtask

   task automatic test_split_levels();
      set_levels(level_type'(511), level_type'(1023), level_type'(1023),
                 level_type'(512), level_type'(1022));
      test_random_traffic(200);
   endtask

   // writes to unused indexes must leave every threshold alone
   task automatic test_unused_index();
      int a;
      wait_idle();
      for (a = CSR_MARKER_MAX + 1; a < (1 << CSR_ADDR_W); a++)
         write_level(csr_addr_type'(a), level_type'($urandom_range(0, 1023)));
      test_random_traffic(100);
   endtask

   always @(posedge clock) begin : ready_pacing
      if (stall_left == 0) stall_left = idle_len();
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // sampled half a cycle ahead of the accepting edge
   always @(negedge clock) begin : result_check
      deframe_result_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result", {rsp_tuser, rsp_tdata}, 0);
         end else begin
            want = pending_results.pop_front();
            check_field("symbol", rsp_tuser[1:0], want.symbol);
            check_field("frame_done", rsp_tuser[2], want.frame_done);
            check_field("hour", rsp_tdata[4:0], want.hour);
            check_field("minute", rsp_tdata[10:5], want.minute);
            check_field("day", rsp_tdata[15:11], want.day);
            check_field("month", rsp_tdata[19:16], want.month);
            check_field("year", rsp_tdata[31:20], want.year);
            check_field("bits_received", rsp_tdata[37:32], want.bits_received);
         end
      end
   end

   always @(negedge clock) begin : watchdog
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("optical_level_deframer test failed");
         $finish;
      end
   end

   initial begin : main_sequence
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_level_bounds();
      test_short_frame();
      test_random_traffic(350);
      test_disjoint_levels();
      test_overlapping_levels();
      test_unused_index();
      test_empty_ranges();
      test_all_black();
      test_split_levels();
      wait_idle();
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("optical_level_deframer test passed");
      end else begin
         $display("optical_level_deframer test failed");
      end
      $finish;
   end

endmodule

// ===== optical_level_deframer.f =====
hdl/old_pkg.sv
hdl/optical_level_deframer.sv
tb/testbench.sv
